// File: rtl/exclusive_time_profiler_macros.svh
// ---------------------------------------------------------------------------
// Exclusive time profiler assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and muted
// while reset is held.
// ---------------------------------------------------------------------------
`ifndef EXCLUSIVE_TIME_PROFILER_MACROS_SVH
`define EXCLUSIVE_TIME_PROFILER_MACROS_SVH

// Condition holds at every edge out of reset
`define ETP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ETP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ETP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/etp_pkg.sv
// ---------------------------------------------------------------------------
// Exclusive time profiler package
// Beat types, frame layout, status codes and the saturating time adder.
// ---------------------------------------------------------------------------
package etp_pkg;

  // Fixed field widths
  localparam int ID_BITS   = 8;
  localparam int TIME_BITS = 32;

  // Default call stack depth
  localparam int STACK_DEPTH_DEF = 16;

  // Result status codes
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  typedef struct packed {
    logic [ID_BITS-1:0]   func_id;
    logic [TIME_BITS-1:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   done_id;
    logic [TIME_BITS-1:0] exclusive_time;
    logic                 status;
  } out_item_t;

  // One call stack frame
  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] total;
    logic [TIME_BITS-1:0] resume;
  } frame_t;

  // Frame memory port controls
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

  // Add two times, clamp at all ones on carry out
  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                  input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum[TIME_BITS]) begin
      return '1;
    end
    return sum[TIME_BITS-1:0];
  endfunction

endpackage

// File: rtl/exclusive_time_profiler.sv
// ---------------------------------------------------------------------------
// Exclusive time profiler
// Call stack profiler that reports each function's own run time.
// ---------------------------------------------------------------------------
// Events are taken one at a time. An event on an empty stack only writes its
// frame; a dropped push onto a full stack reads the top frame, then reports
// the drop; a pop reads the top frame and reports, then, if a frame remains,
// reads it and rewrites its resume time; a push reads the top frame, writes it
// back credited, then writes the new frame. The single frame memory takes one
// read or one write per cycle, with registered read data. Results leave through
// an output register, so the next event is accepted while a result still waits;
// a stalled result holds back only a later event that itself produces a result.
// Stack frames are never cleared, as only entries below the frame count are read.
// ---------------------------------------------------------------------------
module exclusive_time_profiler
  import etp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  mem_cmd_t          cmd;
  logic [ADDR_W-1:0] waddr, raddr;
  frame_t            wdata, rdata;
  logic              res_valid, res_ready;
  out_item_t         res_data;
  logic              out_valid_r;
  out_item_t         out_data_r;

  etp_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cmd       (cmd),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  etp_frame_ram #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .cmd   (cmd),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Take a result when the output register is empty or draining
  assign res_ready = !out_valid_r || !out_stall;

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/etp_frame_ram.sv
// ---------------------------------------------------------------------------
// Exclusive time profiler frame memory
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module etp_frame_ram
  import etp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
  input  logic              clk,
  input  mem_cmd_t          cmd,
  input  logic [ADDR_W-1:0] waddr,
  input  frame_t            wdata,
  input  logic [ADDR_W-1:0] raddr,
  output frame_t            rdata
);

  frame_t mem [STACK_DEPTH];
  frame_t rdata_r;

  // Write the frame
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Read and hold until the next read
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/etp_ctrl.sv
// ---------------------------------------------------------------------------
// Exclusive time profiler stack control
// Keeps the frame count, reads the top frame, credits it and writes back
// pushes and resume times; pops and dropped pushes are reported as results.
// ---------------------------------------------------------------------------
`include "exclusive_time_profiler_macros.svh"

module etp_ctrl
  import etp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(STACK_DEPTH),
  parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              res_valid,
  input  logic              res_ready,
  output out_item_t         res_data,
  output mem_cmd_t          cmd,
  output logic [ADDR_W-1:0] waddr,
  output frame_t            wdata,
  output logic [ADDR_W-1:0] raddr,
  input  frame_t            rdata
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_PUSH   = 2'd2;
  localparam logic [1:0] S_RESUME = 2'd3;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  in_item_t             item_r;
  logic [CNT_W-1:0]     cnt_dec, cnt_dec2, cnt_inc;
  logic [ADDR_W-1:0]    top_idx;
  logic [TIME_BITS-1:0] run_time, total_new;
  logic                 accept, match, full;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign cnt_dec  = count_r - CNT_ONE;
  assign cnt_dec2 = count_r - CNT_TWO;
  assign cnt_inc  = count_r + CNT_ONE;
  assign top_idx  = cnt_dec[ADDR_W-1:0];

  // Credit the top frame with the time since it resumed
  assign run_time  = item_r.event_time - rdata.resume;
  assign total_new = sat_add(rdata.total, run_time);
  assign match     = (rdata.id == item_r.func_id);
  assign full      = (count_r == CNT_FULL);

  // Sequence one event through the frame memory
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cmd       = '0;
    waddr     = top_idx;
    raddr     = top_idx;
    wdata     = '0;
    res_valid = 1'b0;
    res_data  = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (count_r == '0) begin
            cmd.wr_en = 1'b1;
            waddr     = '0;
            wdata     = '{id: in_data.func_id, total: '0, resume: in_data.event_time};
            count_nxt = CNT_ONE;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (match) begin
          res_valid = 1'b1;
          res_data  = '{done_id: item_r.func_id, exclusive_time: total_new,
                        status: STATUS_DONE};
          if (res_ready) begin
            count_nxt = cnt_dec;
            if (cnt_dec != '0) begin
              cmd.rd_en = 1'b1;
              raddr     = cnt_dec2[ADDR_W-1:0];
              state_nxt = S_RESUME;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end else if (full) begin
          res_valid = 1'b1;
          res_data  = '{done_id: item_r.func_id, exclusive_time: '0,
                        status: STATUS_DROP};
          if (res_ready) begin
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.wr_en = 1'b1;
          wdata     = '{id: rdata.id, total: total_new, resume: rdata.resume};
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.wr_en = 1'b1;
        waddr     = count_r[ADDR_W-1:0];
        wdata     = '{id: item_r.func_id, total: '0, resume: item_r.event_time};
        count_nxt = cnt_inc;
        state_nxt = S_IDLE;
      end
      S_RESUME: begin
        cmd.wr_en = 1'b1;
        wdata     = '{id: rdata.id, total: rdata.total, resume: item_r.event_time};
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  `ETP_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_FULL, "count past depth")
  `ETP_ASSERT_ALWAYS(a_one_port_op, clk, rst_n, !(cmd.wr_en && cmd.rd_en), "read with write")
  `ETP_ASSERT_SAME(a_res_in_exec, clk, rst_n, res_valid, state_r == S_EXEC, "result outside exec")
  `ETP_ASSERT_NEXT(a_push_grows, clk, rst_n, state_r == S_PUSH, count_r == $past(cnt_inc), "bad push")

endmodule
